// ===== sv/valve_actuator_self_test_top_assert.svh =====
// Assertion macros for the valve actuator self-test checker.
`ifndef VALVE_ACTUATOR_SELF_TEST_TOP_ASSERT_SVH
`define VALVE_ACTUATOR_SELF_TEST_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VAST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("valve actuator check failed");

// Next-cycle implication, checked outside reset.
`define VAST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("valve actuator check failed");

`endif

// ===== sv/vast_pkg.sv =====
// Shared types, constants and helpers for the valve actuator self-test block.
package vast_pkg;

  localparam int TIMER_BITS = 16;
  localparam int TALLY_BITS = 8;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [32:0] TIMER_MAX_W = (33'd1 << TIMER_BITS) - 33'd1;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [TALLY_BITS-1:0] tally_t;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_OPEN    = 3'd1,
    OP_CLOSE   = 3'd2,
    OP_TEST    = 3'd3,
    OP_EDGE1   = 3'd4,
    OP_EDGE2   = 3'd5,
    OP_CONFIRM = 3'd6
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ACT_DELAY_ONE = 3'd0,
    REG_ACT_DELAY_TWO = 3'd1,
    REG_DETECT_WINDOW = 3'd2,
    REG_OPEN_SETTLE   = 3'd3,
    REG_MIN_TURNS     = 3'd4,
    REG_RELAY_PULSE   = 3'd5
  } reg_idx_t;

  // Events seen by one channel for the word being processed
  typedef struct packed {
    logic tick;
    logic open_cmd;
    logic close_cmd;
    logic test_clear;
    logic test_start;
    logic edge_hit;
  } chan_ev_t;

  // Channel status back to the top level
  typedef struct packed {
    logic drive;
    logic busy;
    logic fail;
    logic judged;
    logic judged_fail;
  } chan_st_t;

  // Zero acts as one; values beyond the timer range saturate.
  function automatic timer_t load_val(input logic [CFG_DATA_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (v == '0) return timer_t'(1);
    if (w > TIMER_MAX_W) return {TIMER_BITS{1'b1}};
    return w[TIMER_BITS-1:0];
  endfunction

endpackage

// ===== sv/valve_actuator_self_test_top.sv =====
// Top level of the two-channel valve actuator controller with rotation self-test.
// A word accepted into the input register is applied at the next advance, and its
// result shows on out_* from the state/result registers (two-register path).
// Throughput: one word per cycle; the input register and the state/result stage
// advance together whenever the result slot is empty or being taken.
// Reset (rst_n low, synchronous): registers take their reset values, both stages
// empty; no clearing pass, words are accepted from the first cycle after reset.
module valve_actuator_self_test_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_opcode,
  input  logic                                in_hall_one,
  input  logic                                in_hall_two,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_valve_one_drive,
  output logic                                out_valve_two_drive,
  output logic                                out_relay_on_coil,
  output logic                                out_relay_off_coil,
  output logic                                out_commanded_open,
  output logic                                out_open_confirmed,
  output logic                                out_fail_one,
  output logic                                out_fail_two,
  output logic                                out_alarm,
  output logic                                out_busy_one,
  output logic                                out_busy_two,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vast_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [vast_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import vast_pkg::*;

  // Input register
  logic     in_v_r;
  op_t      op_r;
  logic     hall_one_r, hall_two_r;

  // Result slot: the state registers below hold the result word itself
  logic     out_v_r;
  logic     adv;

  // Configuration registers
  logic [CFG_DATA_BITS-1:0] act_delay_one_r, act_delay_two_r, detect_window_r;
  logic [CFG_DATA_BITS-1:0] open_settle_r, relay_pulse_r;
  logic [7:0]               min_turns_r;

  // Shared state
  logic   valve_cmd_r, valve_cmd_nxt;
  logic   confirmed_r, confirmed_nxt;
  logic   alarm_r, alarm_nxt;
  timer_t settle_r, settle_nxt, settle_dec;
  timer_t relay_on_r, relay_on_nxt;
  timer_t relay_off_r, relay_off_nxt;

  chan_ev_t ev_one, ev_two;
  chan_st_t st_one, st_two;
  logic     is_tick, is_test;

  // Advance when a word is held and the result slot frees up this cycle
  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      op_r       <= op_t'(in_opcode);
      hall_one_r <= in_hall_one;
      hall_two_r <= in_hall_two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  // Configuration: always ready, a write lands at once; write only while idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_delay_one_r <= 16'd5100;
      act_delay_two_r <= 16'd5000;
      detect_window_r <= 16'd5000;
      open_settle_r   <= 16'd11000;
      min_turns_r     <= 8'd2;
      relay_pulse_r   <= 16'd200;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_ACT_DELAY_ONE: act_delay_one_r <= cfg_data;
        REG_ACT_DELAY_TWO: act_delay_two_r <= cfg_data;
        REG_DETECT_WINDOW: detect_window_r <= cfg_data;
        REG_OPEN_SETTLE:   open_settle_r   <= cfg_data;
        REG_MIN_TURNS:     min_turns_r     <= cfg_data[7:0];
        REG_RELAY_PULSE:   relay_pulse_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the held word into per-channel events
  assign is_tick = (op_r == OP_TICK);
  // self-test only counts while the valve is commanded open
  assign is_test = (op_r == OP_TEST) && valve_cmd_r;

  always_comb begin
    ev_one            = '0;
    ev_one.tick       = is_tick;
    ev_one.open_cmd   = (op_r == OP_OPEN);
    ev_one.close_cmd  = (op_r == OP_CLOSE);
    ev_one.test_clear = is_test;
    ev_one.test_start = is_test && hall_one_r;
    ev_one.edge_hit   = (op_r == OP_EDGE1);
    ev_two            = ev_one;
    ev_two.test_start = is_test && hall_two_r;
    ev_two.edge_hit   = (op_r == OP_EDGE2);
  end

  vast_chan u_chan_one (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .ev            (ev_one),
    .act_delay     (act_delay_one_r),
    .detect_window (detect_window_r),
    .min_turns     (min_turns_r),
    .st            (st_one)
  );

  vast_chan u_chan_two (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .ev            (ev_two),
    .act_delay     (act_delay_two_r),
    .detect_window (detect_window_r),
    .min_turns     (min_turns_r),
    .st            (st_two)
  );

  assign settle_dec = settle_r - timer_t'(1);

  always_comb begin
    valve_cmd_nxt = valve_cmd_r;
    confirmed_nxt = confirmed_r;
    settle_nxt    = settle_r;
    relay_on_nxt  = relay_on_r;
    relay_off_nxt = relay_off_r;
    alarm_nxt     = alarm_r;
    case (op_r)
      OP_TICK: begin
        // settle timer runs on even after close
        if (settle_r != '0) begin
          settle_nxt = settle_dec;
          if (settle_dec == '0) confirmed_nxt = 1'b1;
        end
        if (relay_on_r != '0) relay_on_nxt = relay_on_r - timer_t'(1);
        if (relay_off_r != '0) relay_off_nxt = relay_off_r - timer_t'(1);
        // channel two judged last, so its outcome wins on a shared tick
        if (st_two.judged) begin
          alarm_nxt = st_two.judged_fail;
        end else if (st_one.judged) begin
          alarm_nxt = st_one.judged_fail;
        end
      end
      OP_OPEN: begin
        valve_cmd_nxt = 1'b1;
        settle_nxt    = load_val(open_settle_r);
        relay_off_nxt = '0;
        relay_on_nxt  = load_val(relay_pulse_r);
      end
      OP_CLOSE: begin
        valve_cmd_nxt = 1'b0;
        confirmed_nxt = 1'b0;
        relay_on_nxt  = '0;
        relay_off_nxt = load_val(relay_pulse_r);
      end
      OP_CONFIRM: begin
        confirmed_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valve_cmd_r <= 1'b0;
      confirmed_r <= 1'b0;
      alarm_r     <= 1'b0;
      settle_r    <= '0;
      relay_on_r  <= '0;
      relay_off_r <= '0;
    end else if (adv) begin
      valve_cmd_r <= valve_cmd_nxt;
      confirmed_r <= confirmed_nxt;
      alarm_r     <= alarm_nxt;
      settle_r    <= settle_nxt;
      relay_on_r  <= relay_on_nxt;
      relay_off_r <= relay_off_nxt;
    end
  end

  // State moves only when a new result word is loaded, so it is the result word
  assign out_valid           = out_v_r;
  assign out_valve_one_drive = st_one.drive;
  assign out_valve_two_drive = st_two.drive;
  assign out_relay_on_coil   = (relay_on_r != '0);
  assign out_relay_off_coil  = (relay_off_r != '0);
  assign out_commanded_open  = valve_cmd_r;
  assign out_open_confirmed  = confirmed_r;
  assign out_fail_one        = st_one.fail;
  assign out_fail_two        = st_two.fail;
  assign out_alarm           = alarm_r;
  assign out_busy_one        = st_one.busy;
  assign out_busy_two        = st_two.busy;

endmodule

// ===== sv/vast_chan.sv =====
// One self-test channel: valve drive, wait and detect timer, edge tally, fail flag.
module vast_chan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  vast_pkg::chan_ev_t                  ev,
  input  logic [vast_pkg::CFG_DATA_BITS-1:0]  act_delay,
  input  logic [vast_pkg::CFG_DATA_BITS-1:0]  detect_window,
  input  logic [7:0]                          min_turns,
  output vast_pkg::chan_st_t                  st
);
  import vast_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WAIT   = 2'd1,
    PH_DETECT = 2'd2
  } phase_t;

  phase_t phase_r, phase_nxt;
  timer_t timer_r, timer_nxt, t_dec;
  tally_t tally_r, tally_nxt;
  logic   drive_r, drive_nxt;
  logic   fail_r, fail_nxt;
  logic   judged, short_count;

  assign t_dec       = (timer_r != '0) ? timer_r - timer_t'(1) : '0;
  assign short_count = 16'(tally_r) < 16'(min_turns);

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    tally_nxt = tally_r;
    drive_nxt = drive_r;
    fail_nxt  = fail_r;
    judged    = 1'b0;
    if (ev.tick) begin
      case (phase_r)
        PH_WAIT: begin
          timer_nxt = t_dec;
          if (t_dec == '0) begin
            drive_nxt = 1'b1;
            phase_nxt = PH_DETECT;
            timer_nxt = load_val(detect_window);
          end
        end
        PH_DETECT: begin
          timer_nxt = t_dec;
          if (t_dec == '0) begin
            phase_nxt = PH_IDLE;
            judged    = 1'b1;
            fail_nxt  = short_count;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
        end
      endcase
    end
    if (ev.open_cmd) drive_nxt = 1'b1;
    if (ev.close_cmd) drive_nxt = 1'b0;
    if (ev.test_clear) begin
      tally_nxt = '0;
      fail_nxt  = 1'b0;
    end
    if (ev.test_start) begin
      drive_nxt = 1'b0;
      phase_nxt = PH_WAIT;
      timer_nxt = load_val(act_delay);
    end
    // saturate at all ones
    if (ev.edge_hit && tally_r != {TALLY_BITS{1'b1}}) tally_nxt = tally_r + tally_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      tally_r <= '0;
      drive_r <= 1'b0;
      fail_r  <= 1'b0;
    end else if (en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      tally_r <= tally_nxt;
      drive_r <= drive_nxt;
      fail_r  <= fail_nxt;
    end
  end

  assign st.drive       = drive_r;
  assign st.busy        = (phase_r != PH_IDLE);
  assign st.fail        = fail_r;
  assign st.judged      = en & judged;
  assign st.judged_fail = short_count;

endmodule

// ===== sv/vast_checker.sv =====
// Port-level checker for the valve actuator self-test block, bound to the top level.
`include "valve_actuator_self_test_top_assert.svh"

module vast_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_relay_on_coil,
  input logic out_relay_off_coil,
  input logic out_commanded_open
);

  // a stalled result word stays offered
  `VAST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // off pulse only follows a close with no open since
  `VAST_ASSERT_NOW(a_off_closed, out_valid && out_relay_off_coil, !out_commanded_open)

  // on pulse only follows an open with no close since
  `VAST_ASSERT_NOW(a_on_open, out_valid && out_relay_on_coil, out_commanded_open)

endmodule

bind valve_actuator_self_test_top vast_checker u_vast_checker (.*);
